// ===== rtl/urs_pkg.sv =====
package urs_pkg;

    localparam int SENSORS_DEF = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT = 2'd1;

    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_ALARM   = 2'd1;
    localparam logic [1:0] REQ_CAPTURE = 2'd2;
    localparam logic [1:0] REQ_READ    = 2'd3;

    localparam logic [2:0] ACT_TRIG_LOW  = 3'd0;
    localparam logic [2:0] ACT_TRIG_HIGH = 3'd1;
    localparam logic [2:0] ACT_SCHEDULE  = 3'd2;
    localparam logic [2:0] ACT_CANCEL    = 3'd3;
    localparam logic [2:0] ACT_REPLY     = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SIG   = 3'd1;
    localparam logic [2:0] ST_TIMEOUT  = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_INVALID  = 3'd4;
    localparam logic [2:0] ST_STALE    = 3'd5;

    localparam logic [4:0]  NONE_ID        = 5'd16;
    localparam logic [15:0] TRIG_US        = 16'd10;
    localparam logic [15:0] DEF_TIMEOUT_US = 16'd60000;
    localparam logic [15:0] INTERVAL_US    = 16'd60000;

    localparam int MIN_MM    = 20;
    localparam int MAX_MM    = 4000;
    localparam int SOUND_NUM = 343;
    localparam int SOUND_DEN = 2000;

    localparam logic [15:0] PULSE_MIN = 16'((2 * MIN_MM * 1000) / SOUND_NUM);
    localparam logic [15:0] PULSE_MAX = 16'((2 * MAX_MM * 1000) / SOUND_NUM);

    // distance = (pulse*343 + 1000) / 2000 as one reciprocal multiply
    localparam int          DIST_SH  = 34;
    localparam logic [63:0] DIST_K   = ((64'd1 << DIST_SH) + 64'(SOUND_DEN) - 64'd1)
                                       / 64'(SOUND_DEN);
    localparam logic [63:0] DIST_MUL = DIST_K * 64'(SOUND_NUM);
    localparam logic [63:0] DIST_ADD = DIST_K * 64'(SOUND_DEN / 2);

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  sensor_sel;
        logic [15:0] echo_len_us;
        logic [31:0] time_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  target_sensor;
        logic [15:0] alarm_delay_us;
        logic [11:0] range_mm;
        logic [31:0] stamp_ms;
        logic [2:0]  status;
        logic        sample_ok;
        logic        last;
    } t_res;

    typedef struct packed {
        t_res [2:0] res;
        logic [1:0] n;
    } t_batch;

endpackage

// ===== rtl/urs_req_if.sv =====
interface urs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  sensor_sel;
    logic [15:0] echo_len_us;
    logic [31:0] time_ms;

    modport source(output valid, output req_type, output sensor_sel,
                   output echo_len_us, output time_ms, input ready);
    modport sink(input valid, input req_type, input sensor_sel,
                 input echo_len_us, input time_ms, output ready);
endinterface

// ===== rtl/urs_rsp_if.sv =====
interface urs_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [3:0]  target_sensor;
    logic [15:0] alarm_delay_us;
    logic [11:0] range_mm;
    logic [31:0] stamp_ms;
    logic [2:0]  status;
    logic        sample_ok;
    logic        last;

    modport source(output valid, output action, output target_sensor,
                   output alarm_delay_us, output range_mm, output stamp_ms,
                   output status, output sample_ok, output last, input ready);
    modport sink(input valid, input action, input target_sensor,
                 input alarm_delay_us, input range_mm, input stamp_ms,
                 input status, input sample_ok, input last, output ready);
endinterface

// ===== rtl/ultrasonic_ranging_scheduler.sv =====
// Round-robin scheduler for up to SENSORS ultrasonic range sensors. Each event item
// (start, alarm elapsed, echo capture, sample read) is registered, then processed
// combinationally against the scheduler state and the per-sensor result store,
// which yields zero to three command or reply items, issued from a three-entry
// output buffer one per cycle while the output is ready. An item's results are
// loaded from the input register into the output buffer once it is free, and
// leave from there. The output port sets the rate: an item's results leave one
// after another; while results drain, one further item waits in the input
// register, and items that yield no result pass at one per cycle while the output
// buffer is empty. Configuration writes are taken at any time but belong only to
// idle periods; a sensor count of 0 or above SENSORS keeps the scheduler stopped.
module ultrasonic_ranging_scheduler #(
    parameter int SENSORS = urs_pkg::SENSORS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [urs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    urs_req_if.sink                        i_req,
    urs_rsp_if.source                      o_rsp
);
    import urs_pkg::*;

    t_req   in_item;
    t_req   core_item;
    t_batch batch;
    t_res   res;
    logic   take;
    logic   buf_free;

    assign in_item.req_type    = i_req.req_type;
    assign in_item.sensor_sel  = i_req.sensor_sel;
    assign in_item.echo_len_us = i_req.echo_len_us;
    assign in_item.time_ms     = i_req.time_ms;

    urs_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_item  (in_item),
        .i_free  (buf_free),
        .o_take  (take),
        .o_item  (core_item)
    );

    urs_core #(.SENSORS(SENSORS)) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_req      (core_item),
        .o_batch    (batch)
    );

    urs_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take),
        .i_batch (batch),
        .o_free  (buf_free),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_res   (res)
    );

    assign o_rsp.action         = res.action;
    assign o_rsp.target_sensor  = res.target_sensor;
    assign o_rsp.alarm_delay_us = res.alarm_delay_us;
    assign o_rsp.range_mm       = res.range_mm;
    assign o_rsp.stamp_ms       = res.stamp_ms;
    assign o_rsp.status         = res.status;
    assign o_rsp.sample_ok      = res.sample_ok;
    assign o_rsp.last           = res.last;
endmodule

// ===== rtl/urs_in_reg.sv =====
module urs_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  urs_pkg::t_req i_item,
    input  logic          i_free,
    output logic          o_take,
    output urs_pkg::t_req o_item
);
    import urs_pkg::*;

    logic r_vld;
    t_req r_item;

    assign o_take  = r_vld && i_free;
    assign o_ready = !r_vld || i_free;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (o_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end
endmodule

// ===== rtl/urs_core.sv =====
module urs_core #(
    parameter int SENSORS = urs_pkg::SENSORS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [urs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [urs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_take,
    input  urs_pkg::t_req                    i_req,
    output urs_pkg::t_batch                  o_batch
);
    import urs_pkg::*;

    localparam int         IW        = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam logic [4:0] SENSORS_N = 5'(SENSORS);

    typedef enum logic [3:0] {
        PH_STOP = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_ECHO = 4'b0100,
        PH_WAIT = 4'b1000
    } t_phase;

    logic [4:0]   r_count;
    logic [15:0]  r_timeout;
    logic         r_started;
    t_phase       r_phase;
    logic [4:0]   r_active;
    logic [4:0]   r_next;
    logic [SENSORS-1:0] r_has;
    logic [SENSORS-1:0] r_dvld;
    logic [11:0]  r_dist  [SENSORS];
    logic [31:0]  r_stamp [SENSORS];
    logic [2:0]   r_stat  [SENSORS];

    logic         n_started;
    t_phase       n_phase;
    logic [4:0]   n_active;
    logic [4:0]   n_next;

    logic         cnt_ok;
    logic [4:0]   sid5;
    logic [IW-1:0] sid_ix;
    logic [IW-1:0] act_ix;
    logic [4:0]   succ_act;
    logic [4:0]   succ_sid;
    logic         pulse_ok;
    logic [47:0]  dist_sum;
    logic [11:0]  dist_new;
    logic [15:0]  echo_wait;

    logic         clear;
    logic         wr_en;
    logic         wr_dist_en;
    logic [IW-1:0] wr_idx;
    logic [2:0]   wr_stat;
    logic [2:0]   rd_st;
    logic [11:0]  rd_dist;
    logic [31:0]  rd_stamp;
    t_batch       batch;

    function automatic t_res cmd(logic [2:0] act, logic [3:0] tgt, logic [15:0] dly);
        t_res r;
        r                = '0;
        r.action         = act;
        r.target_sensor  = tgt;
        r.alarm_delay_us = dly;
        return r;
    endfunction

    function automatic logic [4:0] succ(logic [4:0] prev, logic [4:0] cnt);
        logic [4:0] p1;
        p1 = prev + 5'd1;
        return (p1 >= cnt) ? 5'd0 : p1;
    endfunction

    assign cnt_ok    = (r_count != 5'd0) && (r_count <= SENSORS_N);
    assign sid5      = {1'b0, i_req.sensor_sel};
    assign sid_ix    = i_req.sensor_sel[IW-1:0];
    assign act_ix    = r_active[IW-1:0];
    assign succ_act  = succ(r_active, r_count);
    assign succ_sid  = succ(sid5, r_count);
    assign pulse_ok  = (i_req.echo_len_us >= PULSE_MIN) &&
                       (i_req.echo_len_us <= PULSE_MAX);
    assign dist_sum  = 48'(i_req.echo_len_us) * 48'(DIST_MUL) + 48'(DIST_ADD);
    assign dist_new  = dist_sum[DIST_SH +: 12];
    assign echo_wait = (r_timeout == 16'd0) ? DEF_TIMEOUT_US : r_timeout;
    assign o_batch   = batch;

    always_comb begin
        rd_st    = ST_NO_SIG;
        rd_dist  = '0;
        rd_stamp = '0;
        if (!r_started || !cnt_ok) begin
            rd_st = ST_NO_SIG;
        end else if (sid5 >= r_count) begin
            rd_st = ST_INVALID;
        end else if (r_has[sid_ix]) begin
            rd_st = r_stat[sid_ix];
            if (r_active == sid5 && rd_st == ST_OK) begin
                rd_st = ST_STALE;
            end
            rd_dist  = r_dvld[sid_ix] ? r_dist[sid_ix] : 12'd0;
            rd_stamp = r_stamp[sid_ix];
        end
    end

    always_comb begin
        n_started  = r_started;
        n_phase    = r_phase;
        n_active   = r_active;
        n_next     = r_next;
        batch      = '0;
        clear      = 1'b0;
        wr_en      = 1'b0;
        wr_dist_en = 1'b0;
        wr_idx     = act_ix;
        wr_stat    = ST_TIMEOUT;
        if (i_take) begin
            case (i_req.req_type)
                REQ_START: begin
                    clear     = 1'b1;
                    n_started = 1'b0;
                    n_phase   = PH_STOP;
                    n_active  = NONE_ID;
                    n_next    = NONE_ID;
                    if (cnt_ok) begin
                        n_started    = 1'b1;
                        batch.res[0] = cmd(ACT_TRIG_LOW, 4'd0, 16'd0);
                        batch.res[1] = cmd(ACT_TRIG_HIGH, 4'd0, 16'd0);
                        batch.res[2] = cmd(ACT_SCHEDULE, 4'd0, TRIG_US);
                        batch.n      = 2'd3;
                        n_phase      = PH_TRIG;
                        n_active     = 5'd0;
                    end
                end
                REQ_ALARM: begin
                    if (r_started && r_phase != PH_STOP) begin
                        n_phase  = PH_STOP;
                        n_active = NONE_ID;
                        n_next   = NONE_ID;
                        if (cnt_ok) begin
                            case (r_phase)
                                PH_TRIG: begin
                                    if (r_active < r_count) begin
                                        batch.res[0] = cmd(ACT_TRIG_LOW, r_active[3:0], 16'd0);
                                        batch.res[1] = cmd(ACT_SCHEDULE, r_active[3:0],
                                                           echo_wait);
                                        batch.n      = 2'd2;
                                        n_phase      = PH_ECHO;
                                        n_active     = r_active;
                                        n_next       = r_next;
                                    end
                                end
                                PH_ECHO: begin
                                    if (r_active < r_count) begin
                                        wr_en        = 1'b1;
                                        wr_stat      = ST_TIMEOUT;
                                        batch.res[0] = cmd(ACT_SCHEDULE, succ_act[3:0],
                                                           INTERVAL_US);
                                        batch.n      = 2'd1;
                                        n_phase      = PH_WAIT;
                                        n_next       = succ_act;
                                    end
                                end
                                PH_WAIT: begin
                                    if (r_next < r_count) begin
                                        batch.res[0] = cmd(ACT_TRIG_LOW, r_next[3:0], 16'd0);
                                        batch.res[1] = cmd(ACT_TRIG_HIGH, r_next[3:0], 16'd0);
                                        batch.res[2] = cmd(ACT_SCHEDULE, r_next[3:0], TRIG_US);
                                        batch.n      = 2'd3;
                                        n_phase      = PH_TRIG;
                                        n_active     = r_next;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                end
                REQ_CAPTURE: begin
                    if (r_started && cnt_ok && sid5 < r_count &&
                        r_phase == PH_ECHO && r_active == sid5) begin
                        wr_en        = 1'b1;
                        wr_idx       = sid_ix;
                        wr_dist_en   = pulse_ok;
                        wr_stat      = pulse_ok ? ST_OK : ST_RANGE;
                        batch.res[0] = cmd(ACT_CANCEL, i_req.sensor_sel, 16'd0);
                        batch.res[1] = cmd(ACT_SCHEDULE, succ_sid[3:0], INTERVAL_US);
                        batch.n      = 2'd2;
                        n_phase      = PH_WAIT;
                        n_active     = NONE_ID;
                        n_next       = succ_sid;
                    end
                end
                REQ_READ: begin
                    batch.res[0]           = cmd(ACT_REPLY, i_req.sensor_sel, 16'd0);
                    batch.res[0].range_mm  = rd_dist;
                    batch.res[0].stamp_ms  = rd_stamp;
                    batch.res[0].status    = rd_st;
                    batch.res[0].sample_ok = (rd_st == ST_OK);
                    batch.n                = 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 5'd1;
            r_timeout <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SENSOR_COUNT: r_count   <= i_cfg_data[4:0];
                CFG_ECHO_TIMEOUT: r_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_phase   <= PH_STOP;
            r_active  <= NONE_ID;
            r_next    <= NONE_ID;
            r_has     <= '0;
            r_dvld    <= '0;
        end else begin
            r_started <= n_started;
            r_phase   <= n_phase;
            r_active  <= n_active;
            r_next    <= n_next;
            if (clear) begin
                r_has  <= '0;
                r_dvld <= '0;
            end else if (wr_en) begin
                r_has[wr_idx] <= 1'b1;
                if (wr_dist_en) begin
                    r_dvld[wr_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stamp[wr_idx] <= i_req.time_ms;
            r_stat[wr_idx]  <= wr_stat;
            if (wr_dist_en) begin
                r_dist[wr_idx] <= dist_new;
            end
        end
    end
endmodule

// ===== rtl/urs_out_buf.sv =====
module urs_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  urs_pkg::t_batch i_batch,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output urs_pkg::t_res   o_res
);
    import urs_pkg::*;

    logic [1:0] r_cnt;
    t_res [2:0] r_res;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_free  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        o_res      = r_res[0];
        o_res.last = (r_cnt == 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load && o_free) begin
            r_cnt <= i_batch.n;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_res <= i_batch.res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end
endmodule

// ===== dv/ultrasonic_ranging_scheduler_tb.sv =====
module ultrasonic_ranging_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 150000;
    localparam int unsigned PHASE_ITEMS = 20;

    typedef enum logic [1:0] {
        PH_STOPPED,
        PH_TRIG,
        PH_ECHO,
        PH_WAIT_NEXT
    } t_phase;

    class ranging_scoreboard;
        logic [4:0]  sensor_count;
        logic [15:0] echo_timeout;
        bit          started;
        t_phase      ph;
        logic [4:0]  active_id;
        logic [4:0]  next_id;
        logic [11:0] dist_mm[16];
        logic [31:0] stamp_ms[16];
        logic [2:0]  meas_status[16];
        bit          has_result[16];

        t_res        batch[$];
        t_res        awaited[$];
        int unsigned errors;
        int unsigned reported;
        int unsigned checked;
        int unsigned seen_kind[4];
        int unsigned reply_status[6];

        function new();
            sensor_count = 5'd1;
            echo_timeout = 16'd0;
            clear_all();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_SENSOR_COUNT) begin
                sensor_count = data[4:0];
            end else if (idx == CFG_ECHO_TIMEOUT) begin
                echo_timeout = data;
            end
        endfunction

        function bit count_valid();
            return sensor_count >= 5'd1 && sensor_count <= 5'(SENSORS_DEF);
        endfunction

        function void halt();
            ph = PH_STOPPED;
            active_id = NONE_ID;
            next_id = NONE_ID;
        endfunction

        function void clear_all();
            started = 1'b0;
            halt();
            for (int i = 0; i < 16; i++) begin
                dist_mm[i] = '0;
                stamp_ms[i] = '0;
                meas_status[i] = ST_NO_SIG;
                has_result[i] = 1'b0;
            end
        endfunction

        function void add(logic [2:0] act, logic [3:0] tgt, logic [15:0] dly,
                          logic [11:0] mm, logic [31:0] ms, logic [2:0] st);
            t_res c;
            c.action = act;
            c.target_sensor = tgt;
            c.alarm_delay_us = dly;
            c.range_mm = mm;
            c.stamp_ms = ms;
            c.status = st;
            c.sample_ok = (act == ACT_REPLY) && (st == ST_OK);
            c.last = 1'b0;
            if (act == ACT_REPLY) reply_status[st]++;
            batch.push_back(c);
        endfunction

        function void begin_meas(logic [4:0] id);
            add(ACT_TRIG_LOW, id[3:0], '0, '0, '0, '0);
            add(ACT_TRIG_HIGH, id[3:0], '0, '0, '0, '0);
            add(ACT_SCHEDULE, id[3:0], TRIG_US, '0, '0, '0);
            ph = PH_TRIG;
            active_id = id;
            next_id = NONE_ID;
        endfunction

        function void schedule_next(logic [4:0] prev);
            logic [4:0] n;
            n = (sensor_count <= 5'd1) ? prev : 5'((prev + 5'd1) % sensor_count);
            add(ACT_SCHEDULE, n[3:0], INTERVAL_US, '0, '0, '0);
            ph = PH_WAIT_NEXT;
            active_id = NONE_ID;
            next_id = n;
        endfunction

        function void note_event(logic [1:0] kind, logic [3:0] sid, logic [15:0] pulse,
                                 logic [31:0] t);
            t_res        c;
            int unsigned mm;
            logic [2:0]  st;
            batch.delete();
            seen_kind[kind]++;
            case (kind)
                REQ_START: begin
                    clear_all();
                    if (count_valid()) begin
                        started = 1'b1;
                        begin_meas(5'd0);
                    end
                end
                REQ_ALARM: begin
                    if (started && ph != PH_STOPPED) begin
                        if (!count_valid()) begin
                            halt();
                        end else if (ph == PH_TRIG) begin
                            if (active_id >= sensor_count) begin
                                halt();
                            end else begin
                                add(ACT_TRIG_LOW, active_id[3:0], '0, '0, '0, '0);
                                add(ACT_SCHEDULE, active_id[3:0],
                                    echo_timeout == 16'd0 ? DEF_TIMEOUT_US : echo_timeout,
                                    '0, '0, '0);
                                ph = PH_ECHO;
                            end
                        end else if (ph == PH_ECHO) begin
                            if (active_id >= sensor_count) begin
                                halt();
                            end else begin
                                stamp_ms[active_id] = t;
                                meas_status[active_id] = ST_TIMEOUT;
                                has_result[active_id] = 1'b1;
                                schedule_next(active_id);
                            end
                        end else begin
                            if (next_id >= sensor_count) halt();
                            else begin_meas(next_id);
                        end
                    end
                end
                REQ_CAPTURE: begin
                    if (started && count_valid() && {1'b0, sid} < sensor_count &&
                        ph == PH_ECHO && active_id == {1'b0, sid}) begin
                        add(ACT_CANCEL, sid, '0, '0, '0, '0);
                        stamp_ms[sid] = t;
                        has_result[sid] = 1'b1;
                        if (pulse < PULSE_MIN || pulse > PULSE_MAX) begin
                            meas_status[sid] = ST_RANGE;
                        end else begin
                            mm = (32'(pulse) * SOUND_NUM + SOUND_DEN / 2) / SOUND_DEN;
                            dist_mm[sid] = 12'(mm);
                            meas_status[sid] = ST_OK;
                        end
                        schedule_next({1'b0, sid});
                    end
                end
                default: begin
                    if (!started || !count_valid()) begin
                        add(ACT_REPLY, sid, '0, '0, '0, ST_NO_SIG);
                    end else if ({1'b0, sid} >= sensor_count) begin
                        add(ACT_REPLY, sid, '0, '0, '0, ST_INVALID);
                    end else if (!has_result[sid]) begin
                        add(ACT_REPLY, sid, '0, '0, '0, ST_NO_SIG);
                    end else begin
                        st = meas_status[sid];
                        if (active_id == {1'b0, sid} && st == ST_OK) st = ST_STALE;
                        add(ACT_REPLY, sid, '0, dist_mm[sid], stamp_ms[sid], st);
                    end
                end
            endcase
            if (batch.size() > 0) begin
                c = batch.pop_back();
                c.last = 1'b1;
                batch.push_back(c);
            end
            foreach (batch[i]) awaited.push_back(batch[i]);
        endfunction

        function string show(t_res x);
            return $sformatf("act=%0d sensor=%0d delay=%0d mm=%0d ms=%0h st=%0d ok=%0d last=%0d",
                             x.action, x.target_sensor, x.alarm_delay_us, x.range_mm,
                             x.stamp_ms, x.status, x.sample_ok, x.last);
        endfunction

        function void check_output(t_res got);
            t_res exp_res;
            bit   bad;
            checked++;
            if (awaited.size() == 0) begin
                errors++;
                reported++;
                if (reported <= 10) $display("unexpected output: %s", show(got));
                return;
            end
            exp_res = awaited.pop_front();
            bad = (got.action !== exp_res.action) ||
                  (got.target_sensor !== exp_res.target_sensor) ||
                  (got.alarm_delay_us !== exp_res.alarm_delay_us) ||
                  (got.range_mm !== exp_res.range_mm) ||
                  (got.stamp_ms !== exp_res.stamp_ms) ||
                  (got.status !== exp_res.status) ||
                  (got.sample_ok !== exp_res.sample_ok) ||
                  (got.last !== exp_res.last);
            if (bad) begin
                errors++;
                reported++;
                if (reported <= 10) begin
                    $display("mismatch at %0t", $realtime);
                    $display("  expected %s", show(exp_res));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    urs_req_if req_if();
    urs_rsp_if rsp_if();

    ranging_scoreboard sb = new();
    int unsigned       reg_settings;
    int unsigned       cycle_count;

    ultrasonic_ranging_scheduler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n === 1'b1 && req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            sb.note_event(req_if.req_type, req_if.sensor_sel, req_if.echo_len_us,
                          req_if.time_ms);
        end
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.action = rsp_if.action;
            got.target_sensor = rsp_if.target_sensor;
            got.alarm_delay_us = rsp_if.alarm_delay_us;
            got.range_mm = rsp_if.range_mm;
            got.stamp_ms = rsp_if.stamp_ms;
            got.status = rsp_if.status;
            got.sample_ok = rsp_if.sample_ok;
            got.last = rsp_if.last;
            sb.check_output(got);
        end
    end

    initial begin
        int unsigned mode;
        int unsigned stretch;
        int unsigned tick;
        rsp_if.ready = 1'b0;
        mode = 0;
        stretch = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (stretch == 0) begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(20, 80);
            end else begin
                stretch--;
            end
            tick++;
            case (mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_if.ready <= (tick % 5 != 2) && (tick % 5 != 3);
                default: rsp_if.ready <= ($urandom_range(0, 1) == 1);
            endcase
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d outputs outstanding",
                 cycle_count, sb.awaited.size());
        $display("FAILED: results differ");
        $finish;
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_event(logic [1:0] kind, logic [3:0] sid, logic [15:0] pulse,
                              logic [31:0] t);
        req_if.valid <= 1'b1;
        req_if.req_type <= kind;
        req_if.sensor_sel <= sid;
        req_if.echo_len_us <= pulse;
        req_if.time_ms <= t;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int unsigned n);
        req_if.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // hold until every awaited output is back, then let ignored items clear the pipe
    task automatic drain_outputs();
        req_if.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic program_regs(logic [4:0] count, logic [15:0] tmo);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SENSOR_COUNT;
        i_cfg_data <= {11'd0, count};
        sb.write_reg(CFG_SENSOR_COUNT, {11'd0, count});
        @(negedge i_clk);
        i_cfg_idx <= CFG_ECHO_TIMEOUT;
        i_cfg_data <= tmo;
        sb.write_reg(CFG_ECHO_TIMEOUT, tmo);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        reg_settings++;
    endtask

    initial begin
        int unsigned p;
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        logic [1:0]  kind;
        logic [3:0]  sid;
        logic [15:0] pulse;
        logic [4:0]  count_w;
        logic [15:0] tmo_w;

        reg_settings = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SENSOR_COUNT;
        i_cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_START;
        req_if.sensor_sel = '0;
        req_if.echo_len_us = '0;
        req_if.time_ms = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // values after reset: single sensor, default echo timeout
        send_event(REQ_READ, 4'd0, 16'd0, 32'd0);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd5);
        send_event(REQ_CAPTURE, 4'd0, 16'd1000, 32'd6);
        send_event(REQ_START, 4'd0, 16'd0, 32'd0);
        send_event(REQ_READ, 4'd0, 16'd0, 32'd0);
        send_event(REQ_READ, 4'd15, 16'd0, 32'd0);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd10);
        send_event(REQ_CAPTURE, 4'd0, PULSE_MIN, 32'hFFFF_FFFF);
        send_event(REQ_READ, 4'd0, 16'd0, 32'd0);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd70);
        send_event(REQ_READ, 4'd0, 16'd0, 32'd0);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd71);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd0);
        send_event(REQ_READ, 4'd0, 16'd0, 32'd0);
        drain_outputs();

        program_regs(5'd16, 16'hFFFF);
        send_event(REQ_START, 4'd9, 16'd0, 32'd0);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd1);
        send_event(REQ_CAPTURE, 4'd5, 16'd500, 32'd2);
        send_event(REQ_CAPTURE, 4'd0, PULSE_MAX, 32'h8000_0000);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd3);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd4);
        send_event(REQ_CAPTURE, 4'd1, PULSE_MAX + 16'd1, 32'h1234_5678);
        send_event(REQ_READ, 4'd1, 16'd0, 32'd0);
        drain_outputs();

        // next sensor is no longer below the count: the alarm stops the schedule
        program_regs(5'd1, 16'd1);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd5);
        send_event(REQ_START, 4'd0, 16'd0, 32'd0);
        drain_outputs();

        program_regs(5'd0, 16'd0);
        send_event(REQ_ALARM, 4'd0, 16'd0, 32'd6);
        send_event(REQ_CAPTURE, 4'd0, 16'd300, 32'd7);
        send_event(REQ_READ, 4'd0, 16'd0, 32'd0);
        send_event(REQ_START, 4'd0, 16'd0, 32'd0);
        drain_outputs();

        for (p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    count_w = 5'd16;
                    tmo_w = 16'($urandom);
                end
                1: begin
                    count_w = 5'd1;
                    tmo_w = 16'hFFFF;
                end
                default: begin
                    pick = $urandom_range(0, 11);
                    if (pick == 0) count_w = 5'($urandom_range(17, 31));
                    else if (pick == 1) count_w = 5'd0;
                    else count_w = 5'($urandom_range(1, 16));
                    tmo_w = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
                end
            endcase
            program_regs(count_w, tmo_w);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 10);
                for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
                    pick = $urandom_range(0, 99);
                    sid = 4'($urandom);
                    case ($urandom_range(0, 9))
                        0: pulse = 16'($urandom_range(0, PULSE_MIN - 16'd1));
                        1: pulse = 16'($urandom_range(PULSE_MAX + 16'd1, 65535));
                        2: begin
                            case ($urandom_range(0, 3))
                                0: pulse = PULSE_MIN;
                                1: pulse = PULSE_MAX;
                                2: pulse = 16'hFFFF;
                                default: pulse = 16'h0000;
                            endcase
                        end
                        default: pulse = 16'($urandom_range(PULSE_MIN, PULSE_MAX));
                    endcase
                    if (pick < 5) begin
                        kind = 2'($urandom_range(0, 3));
                    end else if (pick < 20) begin
                        kind = REQ_READ;
                        if (sb.active_id != NONE_ID && $urandom_range(0, 1) == 1) begin
                            sid = sb.active_id[3:0];
                        end
                    end else if (pick < 22 || !sb.started || sb.ph == PH_STOPPED) begin
                        kind = REQ_START;
                    end else if (sb.ph == PH_ECHO && $urandom_range(0, 2) != 0) begin
                        kind = REQ_CAPTURE;
                        sid = sb.active_id[3:0];
                    end else begin
                        kind = REQ_ALARM;
                    end
                    send_event(kind, sid, pulse, $urandom);
                    sent++;
                end
                if ($urandom_range(0, 24) == 0) drain_outputs();
                else if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
            end
            drain_outputs();
        end

        drain_outputs();
        $display("Covered %0d events (start %0d, alarm %0d, capture %0d, read %0d) over %0d %s",
                 sb.seen_kind[0] + sb.seen_kind[1] + sb.seen_kind[2] + sb.seen_kind[3],
                 sb.seen_kind[REQ_START], sb.seen_kind[REQ_ALARM],
                 sb.seen_kind[REQ_CAPTURE], sb.seen_kind[REQ_READ], reg_settings,
                 "register settings");
        $display("%0d outputs checked; replies ok %0d, no signal %0d, timeout %0d, %s %0d",
                 sb.checked, sb.reply_status[ST_OK], sb.reply_status[ST_NO_SIG],
                 sb.reply_status[ST_TIMEOUT], "range/invalid/stale",
                 sb.reply_status[ST_RANGE] + sb.reply_status[ST_INVALID] +
                 sb.reply_status[ST_STALE]);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d errors, %0d outputs still awaited", sb.errors, sb.awaited.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/urs_pkg.sv
rtl/urs_req_if.sv
rtl/urs_rsp_if.sv
rtl/urs_in_reg.sv
rtl/urs_core.sv
rtl/urs_out_buf.sv
rtl/ultrasonic_ranging_scheduler.sv
dv/ultrasonic_ranging_scheduler_tb.sv
